FILE: design/hit_point_diffuse_shader_assert.svh
// Assertion macros shared by the checker of the hit point diffuse shader.
// No dependencies; included by the checker file.
`ifndef HIT_POINT_DIFFUSE_SHADER_ASSERT_SVH
`define HIT_POINT_DIFFUSE_SHADER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define HPDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define HPDS_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/hpds_pkg.sv
// Types and constants of the hit point diffuse shader.
// No dependencies; used by every module of the block.
package hpds_pkg;

   // Hit counter
   localparam int CNT_W = 19;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Z = 2'd2;

   // Datapath widths
   localparam int MAG_W  = 32;   // vector component magnitude after the shift
   localparam int RAD_W  = 64;   // sum of squares
   localparam int ROOT_W = 32;   // vector length
   localparam int Q_W    = 31;   // quotient: unit component or attenuation, Q30
   localparam int NUM_W  = 62;   // dividend
   localparam int DEN_W  = 52;   // divisor
   localparam int LANES_SQ = 2;  // normal and light vector
   localparam int LANES_DV = 7;  // six unit components and the attenuation

   localparam logic [NUM_W-1:0] ATT_NUM    = NUM_W'(20) << 46;
   localparam logic [DEN_W-1:0] ATT_BIAS   = DEN_W'(20) << 16;
   localparam logic [Q_W-1:0]   ONE30      = Q_W'(1) << 30;
   localparam logic [Q_W-1:0]   INTEN_BASE = Q_W'(9) << 26;

   typedef struct packed {
      logic              frame_start;
      logic              hit;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [15:0]      red;
      logic [15:0]      green;
      logic [15:0]      blue;
      logic [CNT_W-1:0] hits_so_far;
   } rsp_type;

   // Item state carried alongside the square root unit
   typedef struct packed {
      logic                  hit;
      logic [CNT_W-1:0]      cnt;
      logic [2:0]            nneg;
      logic [2:0]            lneg;
      logic [2:0][MAG_W-1:0] nm;
      logic [2:0][MAG_W-1:0] lm;
      logic [DEN_W-1:0]      att_den;
   } fr_side_type;

   // Item state carried alongside the divider
   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] cnt;
      logic [2:0]       nneg;
      logic [2:0]       lneg;
      logic             nzero;
      logic             lzero;
   } dv_side_type;

endpackage

FILE: design/hpds_sqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes.
// Depends on hpds_pkg.
module hpds_sqrt #(
   parameter int LANES  = 2,
   parameter int SIDE_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [LANES-1:0][hpds_pkg::RAD_W-1:0] in_rad,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [LANES-1:0][hpds_pkg::ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]                    out_side
);
   import hpds_pkg::*;

   localparam int NST = ROOT_W;

   logic [NST-1:0] vld_ff;
   logic [NST:0]   en;
   logic [LANES-1:0][RAD_W-1:0] v_ff [NST];
   logic [LANES-1:0][RAD_W-1:0] r_ff [NST];
   logic [LANES-1:0][RAD_W-1:0] v_in [NST];
   logic [LANES-1:0][RAD_W-1:0] r_in [NST];
   logic [SIDE_W-1:0] side_ff [NST];
   logic [SIDE_W-1:0] side_in [NST];

   // A stage moves when it is empty or the next one moves.
   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Each stage settles one bit of the root.
   always_comb begin
      logic [RAD_W-1:0] vp;
      logic [RAD_W-1:0] rp;
      logic [RAD_W-1:0] bitv;
      logic [RAD_W-1:0] trial;
      for (int k = 0; k < NST; k++) begin
         bitv = RAD_W'(1) << (RAD_W - 2 - 2 * k);
         side_in[k] = (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               vp = in_rad[l];
               rp = '0;
            end else begin
               vp = v_ff[k-1][l];
               rp = r_ff[k-1][l];
            end
            trial = rp + bitv;
            if (vp >= trial) begin
               v_in[k][l] = vp - trial;
               r_in[k][l] = (rp >> 1) + bitv;
            end else begin
               v_in[k][l] = vp;
               r_in[k][l] = rp >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            v_ff[k]    <= v_in[k];
            r_ff[k]    <= r_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // Output of the last stage
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_root[l] = r_ff[NST-1][l][ROOT_W-1:0];
      end
   end
   assign out_side  = side_ff[NST-1];
   assign out_valid = vld_ff[NST-1];

endmodule

FILE: design/hpds_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Depends on hpds_pkg; the quotient must fit in Q_W bits.
module hpds_div #(
   parameter int LANES  = 7,
   parameter int SIDE_W = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [LANES-1:0][hpds_pkg::NUM_W-1:0] in_num,
   input  logic [LANES-1:0][hpds_pkg::DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]                     in_side,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [LANES-1:0][hpds_pkg::Q_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]                     out_side
);
   import hpds_pkg::*;

   localparam int NST = Q_W;

   logic [NST-1:0] vld_ff;
   logic [NST:0]   en;
   logic [LANES-1:0][DEN_W-1:0] rem_ff [NST];
   logic [LANES-1:0][DEN_W-1:0] rem_in [NST];
   logic [LANES-1:0][NUM_W-1:0] num_ff [NST];
   logic [LANES-1:0][NUM_W-1:0] num_in [NST];
   logic [LANES-1:0][DEN_W-1:0] den_ff [NST];
   logic [LANES-1:0][DEN_W-1:0] den_in [NST];
   logic [LANES-1:0][Q_W-1:0]   quo_ff [NST];
   logic [LANES-1:0][Q_W-1:0]   quo_in [NST];
   logic [SIDE_W-1:0] side_ff [NST];
   logic [SIDE_W-1:0] side_in [NST];

   // A stage moves when it is empty or the next one moves.
   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Stage k brings down dividend bit Q_W-1-k and decides one quotient bit.
   always_comb begin
      logic [DEN_W-1:0] remp;
      logic [NUM_W-1:0] nump;
      logic [DEN_W-1:0] denp;
      logic [Q_W-1:0]   quop;
      logic [DEN_W:0]   trial;
      for (int k = 0; k < NST; k++) begin
         side_in[k] = (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               nump = in_num[l];
               denp = in_den[l];
               remp = DEN_W'(in_num[l][NUM_W-1:Q_W]);
               quop = '0;
            end else begin
               nump = num_ff[k-1][l];
               denp = den_ff[k-1][l];
               remp = rem_ff[k-1][l];
               quop = quo_ff[k-1][l];
            end
            trial = {remp, nump[Q_W-1-k]};
            num_in[k][l] = nump;
            den_in[k][l] = denp;
            if (trial >= {1'b0, denp}) begin
               rem_in[k][l] = DEN_W'(trial - {1'b0, denp});
               quo_in[k][l] = quop | (Q_W'(1) << (Q_W - 1 - k));
            end else begin
               rem_in[k][l] = trial[DEN_W-1:0];
               quo_in[k][l] = quop;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            num_ff[k]  <= num_in[k];
            den_ff[k]  <= den_in[k];
            quo_ff[k]  <= quo_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign out_quo   = quo_ff[NST-1];
   assign out_side  = side_ff[NST-1];
   assign out_valid = vld_ff[NST-1];

endmodule

FILE: design/hpds_front.sv
// Front end: hit counter, light vector, magnitudes, squares, sums of squares
// and the attenuation divisor, in five stages. Depends on hpds_pkg.
module hpds_front #(
   parameter int CNT_CAP = 262144
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [31:0]                    light_x,
   input  logic signed [31:0]                    light_y,
   input  logic signed [31:0]                    light_z,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  hpds_pkg::req_type                     in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [hpds_pkg::LANES_SQ-1:0][hpds_pkg::RAD_W-1:0] out_rad,
   output hpds_pkg::fr_side_type                 out_side
);
   import hpds_pkg::*;

   localparam int NST = 5;

   logic [NST-1:0] vld_ff;
   logic [NST:0]   en;

   // Hit counter
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_base;

   // Stage registers
   req_type          s0_req_ff;
   logic [CNT_W-1:0] s0_cnt_ff;
   fr_side_type      s1_side_ff, s1_side_in;
   logic             s1_ls_ff, s1_ls_in;
   fr_side_type      s2_side_ff;
   logic             s2_ls_ff;
   logic [2:0][RAD_W-1:0] s2_nsq_ff, s2_nsq_in, s2_lsq_ff, s2_lsq_in;
   fr_side_type      s3_side_ff;
   logic             s3_ls_ff;
   logic [RAD_W-1:0] s3_sn_ff, s3_sn_in, s3_sl_ff, s3_sl_in;
   fr_side_type      s4_side_ff, s4_side_in;
   logic [RAD_W-1:0] s4_sn_ff, s4_sl_ff;

   // A stage moves when it is empty or the next one moves.
   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Count hits in item order as items are accepted.
   always_comb begin
      cnt_base = in_data.frame_start ? '0 : cnt_ff;
      cnt_in   = cnt_base;
      if (in_data.hit && (cnt_base < CNT_W'(CNT_CAP))) begin
         cnt_in = cnt_base + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (in_valid && en[0]) begin
         cnt_ff <= cnt_in;
      end
   end

   // Stage 1: light vector, magnitudes, signs and the common shift.
   always_comb begin
      logic [2:0][31:0] lgt;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] nrm;
      logic [2:0][31:0] nmag;
      logic [2:0][32:0] ldiff;
      logic [2:0][32:0] lmag;
      logic             ns;
      lgt = {light_z, light_y, light_x};
      pos = {s0_req_ff.pos_z, s0_req_ff.pos_y, s0_req_ff.pos_x};
      nrm = {s0_req_ff.normal_z, s0_req_ff.normal_y, s0_req_ff.normal_x};
      ns = 1'b0;
      s1_ls_in = 1'b0;
      s1_side_in = '0;
      s1_side_in.hit = s0_req_ff.hit;
      s1_side_in.cnt = s0_cnt_ff;
      for (int i = 0; i < 3; i++) begin
         nmag[i] = nrm[i][31] ? (~nrm[i] + 32'd1) : nrm[i];
         ldiff[i] = {lgt[i][31], lgt[i]} - {pos[i][31], pos[i]};
         lmag[i] = ldiff[i][32] ? (~ldiff[i] + 33'd1) : ldiff[i];
         s1_side_in.nneg[i] = nrm[i][31];
         s1_side_in.lneg[i] = ldiff[i][32];
         ns = ns | nmag[i][31];
         s1_ls_in = s1_ls_in | lmag[i][32] | lmag[i][31];
      end
      for (int i = 0; i < 3; i++) begin
         s1_side_in.nm[i] = ns ? (nmag[i] >> 1) : nmag[i];
         s1_side_in.lm[i] = s1_ls_in ? lmag[i][32:1] : lmag[i][31:0];
      end
   end

   // Stage 2: squares of the components.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_nsq_in[i] = RAD_W'(s1_side_ff.nm[i]) * RAD_W'(s1_side_ff.nm[i]);
         s2_lsq_in[i] = RAD_W'(s1_side_ff.lm[i]) * RAD_W'(s1_side_ff.lm[i]);
      end
   end

   // Stage 3: sums of squares.
   assign s3_sn_in = s2_nsq_ff[0] + s2_nsq_ff[1] + s2_nsq_ff[2];
   assign s3_sl_in = s2_lsq_ff[0] + s2_lsq_ff[1] + s2_lsq_ff[2];

   // Stage 4: squared distance in Q16 plus the bias of the attenuation divisor.
   always_comb begin
      s4_side_in = s3_side_ff;
      s4_side_in.att_den = ATT_BIAS +
         (s3_ls_ff ? DEN_W'(s3_sl_ff[RAD_W-1:14]) : DEN_W'(s3_sl_ff[RAD_W-1:16]));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_req_ff <= in_data;
         s0_cnt_ff <= cnt_in;
      end
      if (en[1]) begin
         s1_side_ff <= s1_side_in;
         s1_ls_ff   <= s1_ls_in;
      end
      if (en[2]) begin
         s2_side_ff <= s1_side_ff;
         s2_ls_ff   <= s1_ls_ff;
         s2_nsq_ff  <= s2_nsq_in;
         s2_lsq_ff  <= s2_lsq_in;
      end
      if (en[3]) begin
         s3_side_ff <= s2_side_ff;
         s3_ls_ff   <= s2_ls_ff;
         s3_sn_ff   <= s3_sn_in;
         s3_sl_ff   <= s3_sl_in;
      end
      if (en[4]) begin
         s4_side_ff <= s4_side_in;
         s4_sn_ff   <= s3_sn_ff;
         s4_sl_ff   <= s3_sl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign out_rad   = {s4_sl_ff, s4_sn_ff};
   assign out_side  = s4_side_ff;
   assign out_valid = vld_ff[NST-1];

endmodule

FILE: design/hpds_back.sv
// Back end: dot product, attenuation, intensity and color, in six stages.
// Depends on hpds_pkg; the last stage is the result register.
module hpds_back (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic [hpds_pkg::LANES_DV-1:0][hpds_pkg::Q_W-1:0] in_quo,
   input  hpds_pkg::dv_side_type                          in_side,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output hpds_pkg::rsp_type                              out_data
);
   import hpds_pkg::*;

   localparam int NST = 6;

   logic [NST-1:0] vld_ff;
   logic [NST:0]   en;
   logic [NST-1:0] hit_ff;
   logic [CNT_W-1:0] cnt_ff [NST];

   logic [2:0][61:0]    s0_prod_ff, s0_prod_in;
   logic [2:0]          s0_psgn_ff, s0_psgn_in;
   logic [2:0][Q_W-1:0] s0_half_ff, s0_half_in, s1_half_ff, s2_half_ff, s3_half_ff;
   logic [Q_W-1:0]      s0_att_ff, s1_att_ff;
   logic [31:0]         s1_dot_ff, s1_dot_in;
   logic [32:0]         s2_term_ff, s2_term_in;
   logic [Q_W-1:0]      s3_inten_ff, s3_inten_in;
   logic [2:0][61:0]    s4_col_ff, s4_col_in;
   rsp_type             s5_rsp_ff, s5_rsp_in;

   // A stage moves when it is empty or the next one moves.
   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Stage 0: unit component products and the halves of the normal map.
   always_comb begin
      logic [2:0][Q_W-1:0] qn;
      logic [2:0][Q_W-1:0] ql;
      logic [31:0]         sum;
      for (int i = 0; i < 3; i++) begin
         qn[i] = in_side.nzero ? '0 : in_quo[i];
         ql[i] = in_side.lzero ? '0 : in_quo[3+i];
         s0_prod_in[i] = 62'(qn[i]) * 62'(ql[i]);
         s0_psgn_in[i] = in_side.nneg[i] ^ in_side.lneg[i];
         sum = in_side.nneg[i] ? ({1'b0, ONE30} - {1'b0, qn[i]})
                               : ({1'b0, ONE30} + {1'b0, qn[i]});
         s0_half_in[i] = sum[31:1];
      end
   end

   // Stage 1: dot product, clipped at zero, in Q30.
   always_comb begin
      logic signed [63:0] dot;
      dot = '0;
      for (int i = 0; i < 3; i++) begin
         if (s0_psgn_ff[i]) begin
            dot = dot - signed'({2'b00, s0_prod_ff[i]});
         end else begin
            dot = dot + signed'({2'b00, s0_prod_ff[i]});
         end
      end
      s1_dot_in = (!dot[63] && (dot != '0)) ? dot[61:30] : '0;
   end

   // Stage 2: diffuse term times attenuation.
   always_comb begin
      logic [62:0] prod;
      prod = 63'(s1_dot_ff) * 63'(s1_att_ff);
      s2_term_in = prod[62:30];
   end

   // Stage 3: intensity with its ceiling at one.
   always_comb begin
      logic [37:0] t27;
      logic [38:0] raw;
      t27 = 38'(s2_term_ff) * 38'd27;
      raw = 39'(INTEN_BASE) + 39'(t27 >> 4);
      s3_inten_in = (raw > 39'(ONE30)) ? ONE30 : raw[Q_W-1:0];
   end

   // Stage 4: channel products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_col_in[i] = 62'(s3_half_ff[i]) * 62'(s3_inten_ff);
      end
   end

   // Stage 5: rounding to Q1.15; a miss is black.
   always_comb begin
      logic [2:0][15:0] ch;
      logic [61:0]      rnd;
      for (int i = 0; i < 3; i++) begin
         rnd = s4_col_ff[i] + (62'(1) << 44);
         ch[i] = hit_ff[4] ? rnd[60:45] : '0;
      end
      s5_rsp_in.red         = ch[0];
      s5_rsp_in.green       = ch[1];
      s5_rsp_in.blue        = ch[2];
      s5_rsp_in.hits_so_far = cnt_ff[4];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            hit_ff[k] <= (k == 0) ? in_side.hit : hit_ff[(k == 0) ? 0 : k - 1];
            cnt_ff[k] <= (k == 0) ? in_side.cnt : cnt_ff[(k == 0) ? 0 : k - 1];
         end
      end
      if (en[0]) begin
         s0_prod_ff <= s0_prod_in;
         s0_psgn_ff <= s0_psgn_in;
         s0_half_ff <= s0_half_in;
         s0_att_ff  <= in_quo[6];
      end
      if (en[1]) begin
         s1_dot_ff  <= s1_dot_in;
         s1_half_ff <= s0_half_ff;
         s1_att_ff  <= s0_att_ff;
      end
      if (en[2]) begin
         s2_term_ff <= s2_term_in;
         s2_half_ff <= s1_half_ff;
      end
      if (en[3]) begin
         s3_inten_ff <= s3_inten_in;
         s3_half_ff  <= s2_half_ff;
      end
      if (en[4]) begin
         s4_col_ff <= s4_col_in;
      end
      if (en[5]) begin
         s5_rsp_ff <= s5_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign out_data  = s5_rsp_ff;
   assign out_valid = vld_ff[NST-1];

endmodule

FILE: design/hit_point_diffuse_shader.sv
// Hit point diffuse shader: Lambert shading from a point light at the light position registers, with falloff.
// Stages in order: front end, square root, divider, back end. Throughput: one
// item per cycle while results are taken; every stage can hold an item and a
// stage moves whenever it is empty or the next one moves.
// Reset (synchronous, active high) empties the pipeline, clears the hit
// counter and sets the light position to the origin. Uses hpds_pkg.
module hit_point_diffuse_shader #(
   parameter int FRAME_PIXELS = 262144
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hpds_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hpds_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [hpds_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hpds_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import hpds_pkg::*;

   localparam int CNT_CAP = (FRAME_PIXELS > int'(CNT_MAX)) ? int'(CNT_MAX) : FRAME_PIXELS;

   logic signed [31:0] light_x_ff, light_y_ff, light_z_ff;

   logic        fr_valid, fr_ready;
   logic [LANES_SQ-1:0][RAD_W-1:0] fr_rad;
   fr_side_type fr_side;

   logic        sq_valid, sq_ready;
   logic [LANES_SQ-1:0][ROOT_W-1:0] sq_root;
   logic [$bits(fr_side_type)-1:0]  sq_side_bits;
   fr_side_type sq_side;

   logic [LANES_DV-1:0][NUM_W-1:0] dv_num;
   logic [LANES_DV-1:0][DEN_W-1:0] dv_den;
   dv_side_type dv_in_side;

   logic        dv_valid, dv_ready;
   logic [LANES_DV-1:0][Q_W-1:0]   dv_quo;
   logic [$bits(dv_side_type)-1:0] dv_side_bits;
   dv_side_type dv_side;

   // Light position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         light_z_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LIGHT_X: light_x_ff <= csr_wdata;
            CSR_LIGHT_Y: light_y_ff <= csr_wdata;
            CSR_LIGHT_Z: light_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   hpds_front #(
      .CNT_CAP (CNT_CAP)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .light_x   (light_x_ff),
      .light_y   (light_y_ff),
      .light_z   (light_z_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   hpds_sqrt #(
      .LANES  (LANES_SQ),
      .SIDE_W ($bits(fr_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );
   assign sq_side = sq_side_bits;

   // Divider lanes: three normal components, three light components and
   // the attenuation.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_num[i]   = NUM_W'(sq_side.nm[i]) << 30;
         dv_den[i]   = DEN_W'(sq_root[0]);
         dv_num[3+i] = NUM_W'(sq_side.lm[i]) << 30;
         dv_den[3+i] = DEN_W'(sq_root[1]);
      end
      dv_num[6] = ATT_NUM;
      dv_den[6] = sq_side.att_den;
      dv_in_side.hit   = sq_side.hit;
      dv_in_side.cnt   = sq_side.cnt;
      dv_in_side.nneg  = sq_side.nneg;
      dv_in_side.lneg  = sq_side.lneg;
      dv_in_side.nzero = (sq_root[0] == '0);
      dv_in_side.lzero = (sq_root[1] == '0);
   end

   hpds_div #(
      .LANES  (LANES_DV),
      .SIDE_W ($bits(dv_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_num    (dv_num),
      .in_den    (dv_den),
      .in_side   (dv_in_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quo   (dv_quo),
      .out_side  (dv_side_bits)
   );
   assign dv_side = dv_side_bits;

   hpds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_quo    (dv_quo),
      .in_side   (dv_side),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

FILE: design/hpds_checker.sv
// Port-level checks of the hit point diffuse shader, bound to its top level.
// Depends on hpds_pkg and hit_point_diffuse_shader_assert.svh.
`include "hit_point_diffuse_shader_assert.svh"

module hpds_checker #(
   parameter int FRAME_PIXELS = 262144
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hpds_pkg::rsp_type rsp_data
);
   import hpds_pkg::*;

   localparam int CNT_CAP = (FRAME_PIXELS > int'(CNT_MAX)) ? int'(CNT_MAX) : FRAME_PIXELS;

   // A waiting result item stays offered and unchanged.
   `HPDS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")
   `HPDS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "result item changed while stalled")

   // Colors never exceed one in Q1.15.
   `HPDS_ASSERT(a_color_max, clock, reset, rsp_valid |-> (rsp_data.red <= 16'd32768) && (rsp_data.green <= 16'd32768) && (rsp_data.blue <= 16'd32768), "color channel above one")

   // The hit count never exceeds its ceiling, the frame size capped at CNT_MAX.
   `HPDS_ASSERT(a_count_cap, clock, reset, rsp_valid |-> rsp_data.hits_so_far <= CNT_W'(CNT_CAP), "hit count above its ceiling")

   // Reset empties the pipeline.
   `HPDS_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "result item offered right after reset")

endmodule

bind hit_point_diffuse_shader hpds_checker #(.FRAME_PIXELS(FRAME_PIXELS)) u_checker (.*);

FILE: dv/hit_point_diffuse_shader_tb.sv
// Self-checking testbench of the hit point diffuse shader: streams hit records,
// predicts every pixel's color and hit count, and checks each result in order.
// Depends on hpds_pkg and the hit_point_diffuse_shader module.
`timescale 1ns / 100ps

module hit_point_diffuse_shader_tb;
   import hpds_pkg::*;

   localparam int FRAME_PIXELS = 262144;
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 5000;
   localparam longint ONE_Q30  = 64'd1 << 30;

   typedef longint vec3_type [3];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LIGHT_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type pending_pixels[$];
   rsp_type expected_colors[$];

   // Shadow copies of the light position and the hit counter.
   logic signed [31:0] light_pos [3];
   int unsigned hit_count_shadow;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int stall_cycles = 0;

   hit_point_diffuse_shader #(.FRAME_PIXELS(FRAME_PIXELS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Integer square root, rounded down.
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   // Normalizes a vector to Q2.30 and returns its sum of squares and shift.
   function automatic void normalize(input vec3_type c, output vec3_type u,
                                     output longint unsigned sum_sq, output bit shifted);
      longint unsigned mag [3];
      longint unsigned len;
      longint q;
      shifted = 1'b0;
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
         if (mag[i] >= (64'd1 << 31)) shifted = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >> shifted;
         sum_sq += mag[i] * mag[i];
      end
      len = int_sqrt(sum_sq);
      for (int i = 0; i < 3; i++) begin
         q = (len != 0) ? longint'((mag[i] << 30) / len) : 0;
         u[i] = (c[i] < 0) ? -q : q;
      end
   endfunction

   // Predicts the shaded color of one pixel and advances the hit counter.
   function automatic rsp_type shade_pixel(input req_type px);
      rsp_type r;
      vec3_type nc, lc, nu, lu;
      longint unsigned n_sq, l_sq, dsq, att, dot30, term, inten, half;
      bit n_sh, l_sh;
      longint dot;
      r = '0;
      if (px.frame_start) hit_count_shadow = 0;
      if (!px.hit) begin
         r.hits_so_far = CNT_W'(hit_count_shadow);
         return r;
      end
      if (hit_count_shadow < FRAME_PIXELS) hit_count_shadow++;
      nc[0] = px.normal_x;
      nc[1] = px.normal_y;
      nc[2] = px.normal_z;
      lc[0] = longint'(light_pos[0]) - longint'(px.pos_x);
      lc[1] = longint'(light_pos[1]) - longint'(px.pos_y);
      lc[2] = longint'(light_pos[2]) - longint'(px.pos_z);
      normalize(nc, nu, n_sq, n_sh);
      normalize(lc, lu, l_sq, l_sh);
      dot = nu[0] * lu[0] + nu[1] * lu[1] + nu[2] * lu[2];
      dot30 = (dot > 0) ? (longint'(dot) >> 30) : 0;
      dsq = l_sh ? (l_sq >> 14) : (l_sq >> 16);
      att = (64'd20 << 46) / ((64'd20 << 16) + dsq);
      term = (dot30 * att) >> 30;
      inten = (64'd9 << 26) + ((64'd27 * term) >> 4);
      if (inten > ONE_Q30) inten = ONE_Q30;
      half = longint'(nu[0] + ONE_Q30) >> 1;
      r.red = 16'((half * inten + (64'd1 << 44)) >> 45);
      half = longint'(nu[1] + ONE_Q30) >> 1;
      r.green = 16'((half * inten + (64'd1 << 44)) >> 45);
      half = longint'(nu[2] + ONE_Q30) >> 1;
      r.blue = 16'((half * inten + (64'd1 << 44)) >> 45);
      r.hits_so_far = CNT_W'(hit_count_shadow);
      return r;
   endfunction

   // Picks one coordinate: full range, small, or an extreme.
   function automatic logic [31:0] pick_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
         default: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   // Random pixel: mostly well-formed hits, some near the light or degenerate.
   function automatic req_type random_pixel();
      req_type px;
      int kind;
      kind = $urandom_range(9);
      px.frame_start = ($urandom_range(99) < 3);
      px.hit = ($urandom_range(99) < 85);
      px.pos_x = pick_coord(kind < 3 ? 0 : (kind < 8 ? 1 : 2));
      px.pos_y = pick_coord(kind < 3 ? 0 : (kind < 8 ? 1 : 2));
      px.pos_z = pick_coord(kind < 3 ? 0 : (kind < 8 ? 1 : 2));
      px.normal_x = pick_coord(kind < 4 ? 0 : (kind < 9 ? 1 : 2));
      px.normal_y = pick_coord(kind < 4 ? 0 : (kind < 9 ? 1 : 2));
      px.normal_z = pick_coord(kind < 4 ? 0 : (kind < 9 ? 1 : 2));
      if (kind == 5) begin
         px.normal_x = 0;
         px.normal_y = 0;
         px.normal_z = 0;
      end
      if (kind == 6) begin
         px.pos_x = light_pos[0];
         px.pos_y = light_pos[1];
         px.pos_z = light_pos[2];
      end
      return px;
   endfunction

   // Appends one item to the pending queue.
   task automatic queue_pixel(input req_type px);
      pending_pixels.insert(pending_pixels.size(), px);
   endtask

   // Writes one light register while the block is idle.
   task automatic write_light(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      light_pos[idx] = value;
   endtask

   task automatic set_light(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      write_light(CSR_LIGHT_X, x);
      write_light(CSR_LIGHT_Y, y);
      write_light(CSR_LIGHT_Z, z);
   endtask

   // Waits until every item has gone through, then lets the pipeline settle.
   task automatic drain();
      wait (pending_pixels.size() == 0 && !req_valid && expected_colors.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(input logic fs, input logic h, input logic [31:0] p,
                            input logic [31:0] n0, input logic [31:0] n1,
                            input logic [31:0] n2);
      req_type px;
      px.frame_start = fs;
      px.hit = h;
      px.pos_x = p;
      px.pos_y = p;
      px.pos_z = p;
      px.normal_x = n0;
      px.normal_y = n1;
      px.normal_z = n2;
      queue_pixel(px);
   endtask

   // Driver: presents the next pending item, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_pixels.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts accepted items and checks accepted results.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_valid && req_ready) begin
            expected_colors.insert(expected_colors.size(), shade_pixel(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_colors.size() == 0) begin
               $error("unexpected result item: %p", got);
               errors++;
            end else begin
               want = expected_colors.pop_front();
               if (got.red != want.red) begin
                  $error("red: expected %0d, got %0d", want.red, got.red);
                  errors++;
               end
               if (got.green != want.green) begin
                  $error("green: expected %0d, got %0d", want.green, got.green);
                  errors++;
               end
               if (got.blue != want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, got.blue);
                  errors++;
               end
               if (got.hits_so_far != want.hits_so_far) begin
                  $error("hits_so_far: expected %0d, got %0d",
                         want.hits_so_far, got.hits_so_far);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      light_pos[0] = 0;
      light_pos[1] = 0;
      light_pos[2] = 0;
      hit_count_shadow = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: misses, degenerate vectors, extremes, counter clear.
      send_idle_pct = 11;
      recv_idle_pct = 58;
      set_light(32'h0000_0000, 32'h0000_0000, 32'h0005_0000);
      add_pixel(1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      add_pixel(1'b0, 1'b0, 32'h1234_5678, 32'h0, 32'h0001_0000, 32'h0);
      add_pixel(1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
      add_pixel(1'b0, 1'b1, 32'h0, 32'hffff_0000, 32'h0, 32'h0);
      add_pixel(1'b0, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_pixel(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_pixel(1'b0, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
      add_pixel(1'b0, 1'b1, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
      add_pixel(1'b1, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
      add_pixel(1'b0, 1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'hfffe_0000);
      add_pixel(1'b1, 1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
      drain();
      // Light at the hit point.
      set_light(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      add_pixel(1'b0, 1'b1, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
      add_pixel(1'b0, 1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      // Largest light vector in magnitude.
      drain();
      set_light(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_pixel(1'b0, 1'b1, 32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0);
      add_pixel(1'b0, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      for (int i = 0; i < 280; i++) queue_pixel(random_pixel());
      drain();

      // Second random phase with the other extreme and roles swapped.
      send_idle_pct = 58;
      recv_idle_pct = 11;
      set_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      for (int i = 0; i < 140; i++) queue_pixel(random_pixel());
      drain();
      set_light($urandom_range(65536 * 8), 32'hfffc_0000, $urandom);
      for (int i = 0; i < 140; i++) queue_pixel(random_pixel());
      drain();

      // No idling: random traffic, then a few hits around a frame start.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_light(32'h0000_0000, 32'h0000_0000, 32'h0008_0000);
      for (int i = 0; i < 280; i++) queue_pixel(random_pixel());
      add_pixel(1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      add_pixel(1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      add_pixel(1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
      add_pixel(1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      drain();

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
